// ===== rtl/sp2c_pkg.sv =====
package sp2c_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int TRIG_STAGES     = 24;
    localparam int WORK_FRAC       = 24;
    localparam int ZBITS           = 32;

    localparam int ANGLE_W = 25;
    localparam int DIST_W  = 27;
    localparam int PH_W    = 17;
    localparam int IH_W    = 17;
    localparam int LEN_W   = 41;

    // datapath widths: cordic vector, cordic angle, rounded offset, sums
    localparam int XW = 54;
    localparam int ZW = 42;
    localparam int RW = 31;
    localparam int SW = 44;

    localparam int GAIN_W     = 31;
    localparam int LO_W       = 20;
    localparam int GAIN_SHIFT = GAIN_W - LO_W;
    localparam int MAG_SHIFT  = WORK_FRAC - LO_W;
    localparam int Z_SHIFT    = ZBITS - ANGLE_FRAC_BITS;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_STATION_EAST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STATION_NORTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STATION_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIENTATION    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INSTR_HEIGHT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_ENABLE  = 3'd5;

    localparam logic [ANGLE_W-1:0] FULL_CIRCLE = ANGLE_W'(64'd400 << ANGLE_FRAC_BITS);

    localparam logic signed [ZW-1:0] Z_FULL    = ZW'(64'd400 << ZBITS);
    localparam logic signed [ZW-1:0] Z_HALF    = ZW'(64'd200 << ZBITS);
    localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(64'd100 << ZBITS);

    typedef struct packed {
        logic                   flip;
        logic [ANGLE_W-1:0]     az;
        logic signed [RW-1:0]   vdr;
        logic [PH_W-1:0]        ph;
    } side_t;

    typedef struct packed {
        logic                   flip;
        logic signed [ZW-1:0]   z;
    } fold_t;

    // shift-subtract divide, used only for elaboration-time tables
    function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int j = 63; j >= 0; j--) begin
            r = {r[62:0], a[j]};
            if (r >= b) begin
                r = r - b;
                q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(1/n), Q62 radians
    function automatic longint atan_recip(input logic [63:0] n);
        logic [63:0] p;
        logic [63:0] t;
        longint acc;
        p = udiv(64'd1 << 62, n);
        acc = 0;
        for (int k = 0; k < 40; k++) begin
            if (p != 0) begin
                t = udiv(p, 64'(2 * k + 1));
                acc = k[0] ? acc - longint'(t) : acc + longint'(t);
                p = udiv(p, n * n);
            end
        end
        return acc;
    endfunction

    // atan(2^-i), Q62 radians
    function automatic longint atan_pow2(input int i);
        longint acc;
        logic [63:0] t;
        int e;
        acc = 0;
        for (int k = 0; k < 32; k++) begin
            e = i * (2 * k + 1);
            if (e <= 62) begin
                t = udiv(64'd1 << (62 - e), 64'(2 * k + 1));
                acc = k[0] ? acc - longint'(t) : acc + longint'(t);
            end
        end
        return acc;
    endfunction

    // atan(2^-i) in gon scaled by 2^ZBITS, truncated
    function automatic logic [63:0] atan_val(input int i);
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] f;
        if (i == 0) begin
            return 64'd50 << ZBITS;
        end
        q = 64'(4 * atan_recip(64'd5) - atan_recip(64'd239));
        r = 64'(atan_pow2(i));
        f = '0;
        for (int b = 0; b < 40; b++) begin
            r = r << 1;
            f = f << 1;
            if (r >= q) begin
                r = r - q;
                f = f | 64'd1;
            end
        end
        return (f * 64'd50) >> 8;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] bt;
        v = v_in;
        r = '0;
        bt = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (bt > v) bt = bt >> 2;
        end
        for (int k = 0; k < 32; k++) begin
            if (bt != 0) begin
                if (v >= r + bt) begin
                    v = v - (r + bt);
                    r = (r >> 1) + bt;
                end else begin
                    r = r >> 1;
                end
                bt = bt >> 2;
            end
        end
        return r;
    endfunction

    // reciprocal cordic gain in Q31, truncated
    function automatic logic [63:0] gain_calc();
        logic [63:0] p;
        p = 64'd1 << 62;
        for (int i = 0; i < TRIG_STAGES; i++) begin
            p = p - udiv(p, (64'd1 << (2 * i)) + 64'd1);
        end
        return isqrt64(p);
    endfunction

    localparam logic [GAIN_W-1:0] GAIN_Q31 = GAIN_W'(gain_calc());

    // angle into the cordic range, half turn folded into a sign flip
    function automatic fold_t fold_angle(input logic [ANGLE_W-1:0] a);
        logic signed [ZW-1:0] z;
        fold_t f;
        z = ZW'(a) << Z_SHIFT;
        if (z >= Z_HALF) z = z - Z_FULL;
        f.flip = 1'b0;
        if (z > Z_QUARTER) begin
            z = z - Z_HALF;
            f.flip = 1'b1;
        end else if (z < -Z_QUARTER) begin
            z = z + Z_HALF;
            f.flip = 1'b1;
        end
        f.z = z;
        return f;
    endfunction

    // to whole 0.1 mm, half up
    function automatic logic signed [RW-1:0] round_len(input logic signed [XW-1:0] v);
        logic signed [XW:0] t;
        t = (XW+1)'(v) + (XW+1)'(64'd1 << (WORK_FRAC - 1));
        return RW'(t >>> WORK_FRAC);
    endfunction

    function automatic logic [LEN_W-1:0] sat_len(input logic signed [SW-1:0] v);
        if (v[SW-1:LEN_W-1] == '0 || v[SW-1:LEN_W-1] == '1) begin
            return v[LEN_W-1:0];
        end else if (v[SW-1]) begin
            return {1'b1, {(LEN_W-1){1'b0}}};
        end else begin
            return {1'b0, {(LEN_W-1){1'b1}}};
        end
    endfunction

endpackage

// ===== rtl/sp2c_cordic.sv =====
module sp2c_cordic import sp2c_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 ce,
    input  logic                 in_valid,
    input  logic signed [XW-1:0] in_x,
    input  logic signed [ZW-1:0] in_z,
    input  side_t                in_side,
    output logic                 out_valid,
    output logic signed [XW-1:0] out_x,
    output logic signed [XW-1:0] out_y,
    output side_t                out_side
);

    logic                 vld_reg  [TRIG_STAGES];
    logic signed [XW-1:0] x_reg    [TRIG_STAGES];
    logic signed [XW-1:0] y_reg    [TRIG_STAGES];
    logic signed [ZW-1:0] z_reg    [TRIG_STAGES];
    side_t                side_reg [TRIG_STAGES];

    logic                 v_src [TRIG_STAGES];
    logic signed [XW-1:0] x_src [TRIG_STAGES];
    logic signed [XW-1:0] y_src [TRIG_STAGES];
    logic signed [ZW-1:0] z_src [TRIG_STAGES];
    side_t                s_src [TRIG_STAGES];

    genvar i;
    for (i = 0; i < TRIG_STAGES; i++) begin : g_stage
        localparam logic signed [ZW-1:0] ATAN_I = ZW'(atan_val(i));

        logic signed [XW-1:0] x_next;
        logic signed [XW-1:0] y_next;
        logic signed [ZW-1:0] z_next;

        if (i == 0) begin : g_head
            assign v_src[i] = in_valid;
            assign x_src[i] = in_x;
            assign y_src[i] = '0;
            assign z_src[i] = in_z;
            assign s_src[i] = in_side;
        end else begin : g_link
            assign v_src[i] = vld_reg[i-1];
            assign x_src[i] = x_reg[i-1];
            assign y_src[i] = y_reg[i-1];
            assign z_src[i] = z_reg[i-1];
            assign s_src[i] = side_reg[i-1];
        end

        always_comb begin
            if (!z_src[i][ZW-1]) begin
                x_next = x_src[i] - (y_src[i] >>> i);
                y_next = y_src[i] + (x_src[i] >>> i);
                z_next = z_src[i] - ATAN_I;
            end else begin
                x_next = x_src[i] + (y_src[i] >>> i);
                y_next = y_src[i] - (x_src[i] >>> i);
                z_next = z_src[i] + ATAN_I;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (ce) begin
                vld_reg[i] <= v_src[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                x_reg[i]    <= x_next;
                y_reg[i]    <= y_next;
                z_reg[i]    <= z_next;
                side_reg[i] <= s_src[i];
            end
        end
    end

    assign out_valid = vld_reg[TRIG_STAGES-1];
    assign out_x     = x_reg[TRIG_STAGES-1];
    assign out_y     = y_reg[TRIG_STAGES-1];
    assign out_side  = side_reg[TRIG_STAGES-1];

endmodule

// ===== rtl/survey_polar_to_cartesian_top.sv =====
// Total-station point computation: each measurement word (zenith angle, horizontal
// angle, slope distance, prism height) becomes east, north and height from the
// configured station. One word is accepted every cycle while the result side
// does not stall. The pipeline is two chained pipelined cordic rotators, one
// stage per micro-rotation, plus gain multiply and output stages. A stall on
// the result side holds the whole pipeline. Write the configuration registers
// only while no word is in flight.
module survey_polar_to_cartesian_top import sp2c_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // vertical_angle[24:0], horizontal_angle[49:25], slope_distance[76:50],
    // prism_height[93:77], zero pad [95:94]
    input  logic [95:0]           s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // east[40:0], north[81:41], height[122:82], zero pad [127:123]
    output logic [127:0]          m_tdata,
    // height_valid[0]
    output logic [0:0]            m_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [LEN_W-1:0]      cfg_data
);

    // configuration
    logic signed [LEN_W-1:0] sx_reg;
    logic signed [LEN_W-1:0] sy_reg;
    logic signed [LEN_W-1:0] sz_reg;
    logic [ANGLE_W-1:0]      v0_reg;
    logic [IH_W-1:0]         ih_reg;
    logic                    hen_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sx_reg  <= '0;
            sy_reg  <= '0;
            sz_reg  <= '0;
            v0_reg  <= '0;
            ih_reg  <= '0;
            hen_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_STATION_EAST:   sx_reg  <= cfg_data;
                CFG_STATION_NORTH:  sy_reg  <= cfg_data;
                CFG_STATION_HEIGHT: sz_reg  <= cfg_data;
                CFG_ORIENTATION:    v0_reg  <= cfg_data[ANGLE_W-1:0];
                CFG_INSTR_HEIGHT:   ih_reg  <= cfg_data[IH_W-1:0];
                CFG_HEIGHT_ENABLE:  hen_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic ce;
    logic out_vld_reg;

    assign ce       = !out_vld_reg || m_tready;
    assign s_tready = ce;

    // stage 1: angle reduction
    logic [ANGLE_W-1:0] va_in;
    logic [ANGLE_W-1:0] ha_in;
    logic [ANGLE_W-1:0] va_red;
    logic [ANGLE_W-1:0] ha_red;
    logic [ANGLE_W-1:0] v0_red;
    logic [ANGLE_W:0]   az_sum;
    logic [ANGLE_W-1:0] az_next;

    assign va_in  = s_tdata[24:0];
    assign ha_in  = s_tdata[49:25];
    assign va_red = (va_in >= FULL_CIRCLE) ? va_in - FULL_CIRCLE : va_in;
    assign ha_red = (ha_in >= FULL_CIRCLE) ? ha_in - FULL_CIRCLE : ha_in;
    assign v0_red = (v0_reg >= FULL_CIRCLE) ? v0_reg - FULL_CIRCLE : v0_reg;
    assign az_sum = {1'b0, v0_red} + {1'b0, ha_red};
    assign az_next = (az_sum >= {1'b0, FULL_CIRCLE}) ?
                     ANGLE_W'(az_sum - {1'b0, FULL_CIRCLE}) : az_sum[ANGLE_W-1:0];

    logic               vld1_reg;
    logic [ANGLE_W-1:0] va1_reg;
    logic [ANGLE_W-1:0] az1_reg;
    logic [DIST_W-1:0]  d1_reg;
    logic [PH_W-1:0]    ph1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (ce) begin
            vld1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            va1_reg <= va_red;
            az1_reg <= az_next;
            d1_reg  <= s_tdata[76:50];
            ph1_reg <= s_tdata[93:77];
        end
    end

    // stage 2: fold zenith angle, scale distance by the reciprocal cordic gain
    fold_t        fold1;
    logic [63:0]  p2_next;

    assign fold1   = fold_angle(va1_reg);
    assign p2_next = (64'(d1_reg) << MAG_SHIFT) * 64'(GAIN_Q31);

    logic                 vld2_reg;
    fold_t                f2_reg;
    logic [63:0]          p2_reg;
    logic [ANGLE_W-1:0]   az2_reg;
    logic [PH_W-1:0]      ph2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
        end else if (ce) begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            f2_reg  <= fold1;
            p2_reg  <= p2_next;
            az2_reg <= az1_reg;
            ph2_reg <= ph1_reg;
        end
    end

    side_t                c1_in_side;
    logic                 c1_valid;
    logic signed [XW-1:0] c1_x;
    logic signed [XW-1:0] c1_y;
    side_t                c1_side;

    assign c1_in_side = '{flip: f2_reg.flip, az: az2_reg, vdr: '0, ph: ph2_reg};

    sp2c_cordic u_cordic_vert (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (vld2_reg),
        .in_x      (XW'(p2_reg >> GAIN_SHIFT)),
        .in_z      (f2_reg.z),
        .in_side   (c1_in_side),
        .out_valid (c1_valid),
        .out_x     (c1_x),
        .out_y     (c1_y),
        .out_side  (c1_side)
    );

    // stage 3: horizontal distance magnitude and sign, vertical offset, azimuth fold
    logic signed [XW-1:0] vd3;
    logic signed [XW-1:0] mag3_next;
    logic                 neg3_next;
    fold_t                fold2;

    assign vd3       = c1_side.flip ? -c1_x : c1_x;
    assign mag3_next = c1_y[XW-1] ? -c1_y : c1_y;
    assign neg3_next = (c1_y != '0) && (c1_side.flip ^ c1_y[XW-1]);
    assign fold2     = fold_angle(c1_side.az);

    logic                 vld3_reg;
    logic signed [XW-1:0] mag3_reg;
    logic                 neg3_reg;
    logic signed [RW-1:0] vdr3_reg;
    logic [PH_W-1:0]      ph3_reg;
    fold_t                f3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld3_reg <= 1'b0;
        end else if (ce) begin
            vld3_reg <= c1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            mag3_reg <= mag3_next;
            neg3_reg <= neg3_next;
            vdr3_reg <= round_len(vd3);
            ph3_reg  <= c1_side.ph;
            f3_reg   <= fold2;
        end
    end

    // stage 4: gain multiply in two partial products
    logic                 vld4_reg;
    logic [62:0]          phi4_reg;
    logic [50:0]          plo4_reg;
    logic                 neg4_reg;
    logic signed [RW-1:0] vdr4_reg;
    logic [PH_W-1:0]      ph4_reg;
    fold_t                f4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld4_reg <= 1'b0;
        end else if (ce) begin
            vld4_reg <= vld3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            phi4_reg <= 63'(mag3_reg[51:LO_W]) * 63'(GAIN_Q31);
            plo4_reg <= 51'(mag3_reg[LO_W-1:0]) * 51'(GAIN_Q31);
            neg4_reg <= neg3_reg;
            vdr4_reg <= vdr3_reg;
            ph4_reg  <= ph3_reg;
            f4_reg   <= f3_reg;
        end
    end

    // stage 5: combine partial products, restore sign
    logic [63:0]          r5;
    logic signed [XW-1:0] x5_next;

    assign r5      = (64'(phi4_reg) + 64'(plo4_reg >> LO_W)) >> GAIN_SHIFT;
    assign x5_next = neg4_reg ? -XW'(r5) : XW'(r5);

    logic                 vld5_reg;
    logic signed [XW-1:0] x5_reg;
    logic signed [RW-1:0] vdr5_reg;
    logic [PH_W-1:0]      ph5_reg;
    fold_t                f5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld5_reg <= 1'b0;
        end else if (ce) begin
            vld5_reg <= vld4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            x5_reg   <= x5_next;
            vdr5_reg <= vdr4_reg;
            ph5_reg  <= ph4_reg;
            f5_reg   <= f4_reg;
        end
    end

    side_t                c2_in_side;
    logic                 c2_valid;
    logic signed [XW-1:0] c2_x;
    logic signed [XW-1:0] c2_y;
    side_t                c2_side;

    assign c2_in_side = '{flip: f5_reg.flip, az: '0, vdr: vdr5_reg, ph: ph5_reg};

    sp2c_cordic u_cordic_horiz (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (vld5_reg),
        .in_x      (x5_reg),
        .in_z      (f5_reg.z),
        .in_side   (c2_in_side),
        .out_valid (c2_valid),
        .out_x     (c2_x),
        .out_y     (c2_y),
        .out_side  (c2_side)
    );

    // stage 6: round offsets and add station
    logic signed [XW-1:0] e_off;
    logic signed [XW-1:0] n_off;

    assign e_off = c2_side.flip ? -c2_y : c2_y;
    assign n_off = c2_side.flip ? -c2_x : c2_x;

    logic                 vld6_reg;
    logic signed [SW-1:0] e6_reg;
    logic signed [SW-1:0] n6_reg;
    logic signed [SW-1:0] h6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld6_reg <= 1'b0;
        end else if (ce) begin
            vld6_reg <= c2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            e6_reg <= SW'(sx_reg) + SW'(round_len(e_off));
            n6_reg <= SW'(sy_reg) + SW'(round_len(n_off));
            h6_reg <= SW'(sz_reg) + SW'(ih_reg) + SW'(c2_side.vdr) - SW'(c2_side.ph);
        end
    end

    // output register
    logic [LEN_W-1:0] east_reg;
    logic [LEN_W-1:0] north_reg;
    logic [LEN_W-1:0] height_reg;
    logic             hv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (ce) begin
            out_vld_reg <= vld6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            east_reg   <= sat_len(e6_reg);
            north_reg  <= sat_len(n6_reg);
            height_reg <= hen_reg ? sat_len(h6_reg) : '0;
            hv_reg     <= hen_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'b0, height_reg, north_reg, east_reg};
    assign m_tuser  = hv_reg;

`ifndef SYNTH
    a_height_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[122:82] == '0)
        else $error("height not zero while disabled");

    a_height_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[0] == hen_reg)
        else $error("height_valid differs from enable");

    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");
`endif

endmodule
